// ===== hdl/bpa_pkg.sv =====
// Shared constants, widths and status codes for the bitmap page allocator.
`default_nettype none

package bpa_pkg;

    // Region geometry
    localparam int MAP_WORDS   = 32;
    localparam int WORD_BITS   = 32;
    localparam int PAGE_BYTES  = 4096;     // power of two
    localparam int GROW_BYTES  = 65536;
    localparam int TOTAL_PAGES = MAP_WORDS * WORD_BITS;

    // Derived widths
    localparam int ADDR_W     = 32;
    localparam int WIDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int PAGE_W     = WIDX_W + BIT_W;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PNUM_W     = ADDR_W - PAGE_SHIFT;

    // Result field widths
    localparam int STATUS_W = 2;
    localparam int COMMIT_W = 23;
    localparam int COUNT_W  = 11;

    // Request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/bpa_if.sv =====
// Valid/ready channel interfaces: request, response and configuration write.
`default_nettype none

interface bpa_req_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] addr;

    modport source (output valid, output req_type, output addr, input ready);
    modport sink   (input valid, input req_type, input addr, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_addr;
    logic                grew;
    logic [COMMIT_W-1:0] committed_bytes;
    logic [COUNT_W-1:0]  alloc_count;

    modport source (output valid, output status, output page_addr, output grew,
                    output committed_bytes, output alloc_count, input ready);
    modport sink   (input valid, input status, input page_addr, input grew,
                    input committed_bytes, input alloc_count, output ready);
endinterface

interface bpa_cfg_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bitmap_page_allocator_top.sv =====
// Bitmap page allocator: first-fit scan from a hint word, one bitmap word per read.
// Allocate: result loaded through states RD, ACHK, AUPD and RESP, plus another RD
//   and ACHK per all-ones bitmap word skipped (bound by the single bitmap read port).
// Free: result via FOFS, RD, FUPD and RESP; a free outside the region goes FOFS to RESP.
// One item at a time: the next item is taken the cycle after the result is loaded.
// Reset (synchronous, active low) frees every page through per-word valid bits,
//   clears hint, count, committed size and base address; no clearing pass.
`default_nettype none

module bitmap_page_allocator_top
    import bpa_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    bpa_cfg_if.sink     i_cfg,
    bpa_req_if.sink     i_req,
    bpa_rsp_if.source   o_rsp
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_FOFS = 7'b0000010,
        S_RD   = 7'b0000100,
        S_ACHK = 7'b0001000,
        S_AUPD = 7'b0010000,
        S_FUPD = 7'b0100000,
        S_RESP = 7'b1000000
    } t_state;

    // Control and state registers
    t_state              r_state, n_state;
    logic                r_op;
    logic [ADDR_W-1:0]   r_base;
    logic [WIDX_W-1:0]   r_hint;
    logic [COUNT_W-1:0]  r_count;
    logic [COMMIT_W-1:0] r_committed;
    logic [MAP_WORDS-1:0] r_wvld;
    logic                r_rvld;
    logic                r_ovalid;

    // Working and payload registers
    logic [WIDX_W-1:0]   r_word;
    logic [BIT_W-1:0]    r_bit;
    logic [ADDR_W-1:0]   r_offset;
    logic [WORD_BITS-1:0] r_rdata;
    logic [STATUS_W-1:0] r_res_status;
    logic [ADDR_W-1:0]   r_res_paddr;
    logic                r_res_grew;
    logic [STATUS_W-1:0] r_o_status;
    logic [ADDR_W-1:0]   r_o_paddr;
    logic                r_o_grew;
    logic [COMMIT_W-1:0] r_o_committed;
    logic [COUNT_W-1:0]  r_o_count;

    // Bitmap store
    logic [WORD_BITS-1:0] mem_map [MAP_WORDS];

    logic                 w_req_acc;
    logic                 w_out_free;
    logic [WORD_BITS-1:0] w_rword;
    logic                 w_full;
    logic [WORD_BITS-1:0] w_lowclr;
    logic [BIT_W-1:0]     w_lowbit;
    logic [PNUM_W-1:0]    w_pnum;
    logic                 w_in_range;
    logic [PAGE_W-1:0]    w_page;
    logic [COMMIT_W-1:0]  w_end;
    logic [WORD_BITS-1:0] w_bitmask;
    logic                 w_wr_en;
    logic [WORD_BITS-1:0] w_wr_data;

    // Handshakes
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_ovalid || o_rsp.ready;

    // Word just read; never-written words read as all free
    assign w_rword = r_rvld ? r_rdata : '0;
    assign w_full  = &w_rword;

    // Lowest clear bit: isolate it with one add, then encode the one-hot
    assign w_lowclr = ~w_rword & (w_rword + WORD_BITS'(1));
    always_comb begin
        w_lowbit = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w_lowclr[i]) begin
                w_lowbit = w_lowbit | BIT_W'(i);
            end
        end
    end

    // Free address to page number and range check
    assign w_pnum     = r_offset[ADDR_W-1:PAGE_SHIFT];
    assign w_in_range = (w_pnum < PNUM_W'(TOTAL_PAGES));

    // Page arithmetic for the update step
    assign w_page    = {r_word, r_bit};
    assign w_end     = (COMMIT_W'(w_page) + COMMIT_W'(1)) << PAGE_SHIFT;
    assign w_bitmask = WORD_BITS'(1) << r_bit;

    // Bitmap write in the update states
    assign w_wr_en   = (r_state == S_AUPD) || (r_state == S_FUPD);
    assign w_wr_data = (r_state == S_AUPD) ? (w_rword | w_bitmask) : (w_rword & ~w_bitmask);

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    n_state = (i_req.req_type == REQ_FREE) ? S_FOFS : S_RD;
                end
            end
            S_FOFS: begin
                n_state = w_in_range ? S_RD : S_RESP;
            end
            S_RD: begin
                n_state = (r_op == REQ_FREE) ? S_FUPD : S_ACHK;
            end
            S_ACHK: begin
                if (!w_full) begin
                    n_state = S_AUPD;
                end else if (r_word == WIDX_W'(MAP_WORDS - 1)) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_RD;
                end
            end
            S_AUPD: n_state = S_RESP;
            S_FUPD: n_state = S_RESP;
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_hint      <= '0;
            r_count     <= '0;
            r_committed <= '0;
            r_wvld      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_base <= i_cfg.data;
            end
            if (w_wr_en) begin
                r_wvld[r_word] <= 1'b1;
            end
            // Allocation: hint moves to the word used, count up, maybe grow
            if (r_state == S_AUPD) begin
                r_hint  <= r_word;
                r_count <= r_count + COUNT_W'(1);
                if (w_end > r_committed) begin
                    r_committed <= w_end + COMMIT_W'(GROW_BYTES);
                end
            end
            // Free: hint lowered, count saturates at zero
            if (r_state == S_FUPD) begin
                if (r_word < r_hint) begin
                    r_hint <= r_word;
                end
                if (r_count != '0) begin
                    r_count <= r_count - COUNT_W'(1);
                end
            end
            if (r_state == S_RESP && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Read valid flag follows the registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= 1'b0;
        end else if (r_state == S_RD) begin
            r_rvld <= r_wvld[r_word];
        end
    end

    // Bitmap memory: one read and one write port, registered read data
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_rdata <= mem_map[r_word];
        end
        if (w_wr_en) begin
            mem_map[r_word] <= w_wr_data;
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    r_op     <= i_req.req_type;
                    r_word   <= r_hint;
                    r_offset <= i_req.addr - r_base;
                end
            end
            S_FOFS: begin
                r_word       <= w_pnum[PAGE_W-1:BIT_W];
                r_bit        <= w_pnum[BIT_W-1:0];
                r_res_status <= ST_RANGE;
                r_res_paddr  <= '0;
                r_res_grew   <= 1'b0;
            end
            S_RD: begin
            end
            S_ACHK: begin
                r_bit <= w_lowbit;
                if (w_full) begin
                    r_word       <= r_word + WIDX_W'(1);
                    r_res_status <= ST_FULL;
                    r_res_paddr  <= '0;
                    r_res_grew   <= 1'b0;
                end
            end
            S_AUPD: begin
                r_res_status <= ST_OK;
                r_res_paddr  <= r_base + (ADDR_W'(w_page) << PAGE_SHIFT);
                r_res_grew   <= (w_end > r_committed);
            end
            S_FUPD: begin
                r_res_status <= ST_OK;
                r_res_paddr  <= '0;
                r_res_grew   <= 1'b0;
            end
            S_RESP: begin
                if (w_out_free) begin
                    r_o_status    <= r_res_status;
                    r_o_paddr     <= r_res_paddr;
                    r_o_grew      <= r_res_grew;
                    r_o_committed <= r_committed;
                    r_o_count     <= r_count;
                end
            end
            default: begin
            end
        endcase
    end

    // Response channel
    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.page_addr       = r_o_paddr;
    assign o_rsp.grew            = r_o_grew;
    assign o_rsp.committed_bytes = r_o_committed;
    assign o_rsp.alloc_count     = r_o_count;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(TOTAL_PAGES))
        else $error("allocated page count above region size");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc |=> (r_state != S_IDLE))
        else $error("sequencer did not start on an accepted item");

    a_grew_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.grew) |-> (o_rsp.status == ST_OK))
        else $error("growth flagged on a failed request");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.page_addr == '0))
        else $error("failed request returned a page address");

    a_alloc_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AUPD) |=> (r_count == $past(r_count) + COUNT_W'(1)))
        else $error("allocation did not raise the page count");

endmodule

`default_nettype wire
